// ===== sv/bpr8_pkg.sv =====
// Shared types and constants of the RGBA8 preview converter.
package bpr8_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned CHAN_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned DIST_W  = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR   = 2'd3;

  localparam logic [MODE_W-1:0] MODE_RGB    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_RGBA   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_RED    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_GREEN  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_BLUE   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_DNORM  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DLIN   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_MOTION = 4'd7;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 4'd8;

  localparam logic CMD_SCAN    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned MUL_STEPS  = 32;
  localparam int unsigned MUL_CNT_W  = 6;

  localparam int unsigned DIV_W      = 64;
  localparam int unsigned DIV_LOW_W  = 32;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam int unsigned LIN_STEPS  = 31;
  localparam int unsigned BYTE_STEPS = 8;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem_init;
    logic [DIV_LOW_W-1:0] low_bits;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_LOW_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/bpr8_in_if.sv =====
// Input item channel of the preview converter.
interface bpr8_in_if
  import bpr8_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic                     frame_start;
  logic signed [CHAN_W-1:0] chan_zero;
  logic signed [CHAN_W-1:0] chan_one;
  logic signed [CHAN_W-1:0] chan_two;
  logic signed [CHAN_W-1:0] chan_three;

  modport source (output valid, cmd, frame_start, chan_zero, chan_one, chan_two, chan_three,
                  input ready);
  modport sink (input valid, cmd, frame_start, chan_zero, chan_one, chan_two, chan_three,
                output ready);
endinterface

// ===== sv/bpr8_out_if.sv =====
// Result item channel of the preview converter.
interface bpr8_out_if
  import bpr8_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_byte;
  logic [BYTE_W-1:0] green_byte;
  logic [BYTE_W-1:0] blue_byte;
  logic [BYTE_W-1:0] alpha_byte;

  modport source (output valid, red_byte, green_byte, blue_byte, alpha_byte, input ready);
  modport sink (input valid, red_byte, green_byte, blue_byte, alpha_byte, output ready);
endinterface

// ===== sv/bpr8_cfg_if.sv =====
// Configuration write channel of the preview converter.
interface bpr8_cfg_if
  import bpr8_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/buffer_preview_to_rgba8_core.sv =====
// Top level of the RGBA8 preview converter: sequencer, depth statistics, byte unit.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    cmd, frame_start, chan_zero..chan_three
//   out_ch   out  valid/ready    red_byte, green_byte, blue_byte, alpha_byte
//   cfg_ch   in   valid/ready    index, data (always ready)
//
// One item at a time; a convert item outside depth modes takes 4 byte steps.
// Normalized depth adds the ST_DEPTH and ST_DCHK states, plus the serial byte divider when needed.
// Linearized depth adds two 32-step serial multiplies and a 31-step serial division;
// the division is skipped when the depth saturates.
// A scan item outside depth modes ends on acceptance; in depth modes it updates the bounds in ST_DEPTH.
// A finished item waits in the output register; the next item is accepted meanwhile.
// rst_n is synchronous; it clears registers to their reset values and depth bounds to 1.0/0.
module buffer_preview_to_rgba8_core
  import bpr8_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bpr8_in_if.sink      in_ch,
  bpr8_out_if.source   out_ch,
  bpr8_cfg_if.sink     cfg_ch
);

  localparam logic signed [CHAN_W-1:0] ONE_32 = CHAN_W'(64'd1 << FRAC_BITS);
  localparam logic signed [33:0]       ONE_34 = 34'(64'd1 << FRAC_BITS);
  localparam logic signed [33:0]       TWO_34 = 34'(64'd2 << FRAC_BITS);
  localparam logic signed [63:0]       ONE_64 = 64'(64'd1 << FRAC_BITS);
  localparam logic [41:0]              HALF_42 = 42'(64'd1 << (FRAC_BITS - 1));
  localparam logic [41:0]              ONE_42  = 42'(64'd1 << FRAC_BITS);
  localparam logic [DIST_W-1:0]        NEAR_RST = DIST_W'(64'd1 << FRAC_BITS);
  localparam logic [DIST_W-1:0]        FAR_RST  = DIST_W'(64'd100 << FRAC_BITS);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_MUL_NF   = 10'b0000000010,
    ST_MUL_VD   = 10'b0000000100,
    ST_DEN      = 10'b0000001000,
    ST_DIV_LIN  = 10'b0000010000,
    ST_DEPTH    = 10'b0000100000,
    ST_DCHK     = 10'b0001000000,
    ST_DIV_BYTE = 10'b0010000000,
    ST_BYTES    = 10'b0100000000,
    ST_EMIT     = 10'b1000000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [MODE_W-1:0]          mode_r, mode_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [DIST_W-1:0]          near_r, near_nxt;
  logic [DIST_W-1:0]          far_r, far_nxt;
  logic                       cmd_r, cmd_nxt;
  logic signed [CHAN_W-1:0]   c0_r, c0_nxt;
  logic signed [CHAN_W-1:0]   c1_r, c1_nxt;
  logic signed [CHAN_W-1:0]   c2_r, c2_nxt;
  logic signed [CHAN_W-1:0]   c3_r, c3_nxt;
  logic signed [CHAN_W-1:0]   low_r, low_nxt;
  logic signed [CHAN_W-1:0]   high_r, high_nxt;
  logic [61:0]                nf_r, nf_nxt;
  logic signed [63:0]         d2_r, d2_nxt;
  logic signed [CHAN_W-1:0]   depth_r, depth_nxt;
  logic signed [CHAN_W:0]     range_r, range_nxt;
  logic signed [CHAN_W:0]     num_r, num_nxt;
  logic [BYTE_W-1:0]          dbyte_r, dbyte_nxt;
  logic [1:0]                 idx_r, idx_nxt;
  logic [3:0][BYTE_W-1:0]     pix_r, pix_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [3:0][BYTE_W-1:0]     out_pix_r, out_pix_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                       is_depth;
  logic                       has_g, has_b, has_a;
  logic [MUL_W-1:0]           mag_v, mag_d;
  logic signed [CHAN_W-1:0]   dist_diff;
  logic                       prod_neg;
  logic signed [63:0]         sprod;
  logic [63:0]                den;
  logic [30:0]                nf_hi;
  logic signed [CHAN_W:0]     rng_raw, num_raw;
  logic [41:0]                bdvd;

  logic signed [CHAN_W-1:0]   sel_val;
  logic                       sel_half;
  logic                       sel_fix;
  logic [BYTE_W-1:0]          fix_val;
  logic signed [33:0]         bw;
  logic [41:0]                bprod;
  logic [41:0]                bsum;
  logic [BYTE_W-1:0]          byte_val;

  bpr8_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  bpr8_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign is_depth = (mode_r == MODE_DNORM) || (mode_r == MODE_DLIN);
  assign has_g    = count_r >= CNT_W'(2);
  assign has_b    = count_r >= CNT_W'(3);
  assign has_a    = count_r >= CNT_W'(4);

  // linearized depth operands
  always_comb begin
    mag_v     = c0_r[CHAN_W-1] ? MUL_W'(-c0_r) : MUL_W'(c0_r);
    dist_diff = $signed({1'b0, far_r}) - $signed({1'b0, near_r});
    mag_d     = dist_diff[CHAN_W-1] ? MUL_W'(-dist_diff) : MUL_W'(dist_diff);
    prod_neg  = c0_r[CHAN_W-1] ^ dist_diff[CHAN_W-1];
    sprod     = prod_neg ? -$signed(mul_rsp.product) : $signed(mul_rsp.product);
    den       = (d2_r < ONE_64) ? 64'd1 : (64'(d2_r) >> FRAC_BITS);
    nf_hi     = nf_r[61:31];
    rng_raw   = $signed({high_r[CHAN_W-1], high_r}) - $signed({low_r[CHAN_W-1], low_r});
    num_raw   = $signed({depth_r[CHAN_W-1], depth_r}) - $signed({low_r[CHAN_W-1], low_r});
    bdvd      = ({10'd0, num_r[CHAN_W-1:0]} << 9) - ({10'd0, num_r[CHAN_W-1:0]} << 1)
                + {10'd0, range_r[CHAN_W-1:0]};
  end

  // byte lane selection
  always_comb begin
    sel_val  = c0_r;
    sel_half = 1'b0;
    sel_fix  = 1'b0;
    fix_val  = 8'd255;
    if (idx_r == 2'd3) begin
      if (mode_r == MODE_RGBA) begin
        sel_val = has_a ? c3_r : ONE_32;
      end else begin
        sel_fix = 1'b1;
      end
    end else begin
      case (mode_r)
        MODE_RED: sel_val = c0_r;
        MODE_GREEN: sel_val = has_g ? c1_r : c0_r;
        MODE_BLUE: sel_val = has_b ? c2_r : c0_r;
        MODE_DNORM, MODE_DLIN: begin
          sel_fix = 1'b1;
          fix_val = dbyte_r;
        end
        MODE_MOTION, MODE_NORMAL: begin
          sel_half = 1'b1;
          case (idx_r)
            2'd0: sel_val = c0_r;
            2'd1: sel_val = has_g ? c1_r : '0;
            default: begin
              if (mode_r == MODE_MOTION) begin
                sel_fix = 1'b1;
                fix_val = 8'd128;
              end else begin
                sel_val = has_b ? c2_r : '0;
              end
            end
          endcase
        end
        default: begin
          case (idx_r)
            2'd0: sel_val = c0_r;
            2'd1: sel_val = has_g ? c1_r : c0_r;
            default: sel_val = has_b ? c2_r : c0_r;
          endcase
        end
      endcase
    end
  end

  // clamp, scale by 255 and round half up
  always_comb begin
    bw    = 34'(sel_val) + (sel_half ? ONE_34 : 34'sd0);
    bprod = (42'(bw) << 8) - 42'(bw);
    bsum  = bprod + (sel_half ? ONE_42 : HALF_42);
    if (sel_fix) begin
      byte_val = fix_val;
    end else if (bw <= 34'sd0) begin
      byte_val = '0;
    end else if (bw >= (sel_half ? TWO_34 : ONE_34)) begin
      byte_val = 8'd255;
    end else if (sel_half) begin
      byte_val = BYTE_W'(bsum >> (FRAC_BITS + 1));
    end else begin
      byte_val = BYTE_W'(bsum >> FRAC_BITS);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    near_nxt      = near_r;
    far_nxt       = far_r;
    cmd_nxt       = cmd_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    c3_nxt        = c3_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    nf_nxt        = nf_r;
    d2_nxt        = d2_r;
    depth_nxt     = depth_r;
    range_nxt     = range_r;
    num_nxt       = num_r;
    dbyte_nxt     = dbyte_r;
    idx_nxt       = idx_r;
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    mul_req       = '0;
    div_req       = '0;

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MODE:  mode_nxt  = cfg_ch.data[MODE_W-1:0];
        CFG_COUNT: count_nxt = cfg_ch.data[CNT_W-1:0];
        CFG_NEAR:  near_nxt  = cfg_ch.data[DIST_W-1:0];
        CFG_FAR:   far_nxt   = cfg_ch.data[DIST_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.cmd;
          c0_nxt  = in_ch.chan_zero;
          c1_nxt  = in_ch.chan_one;
          c2_nxt  = in_ch.chan_two;
          c3_nxt  = in_ch.chan_three;
          idx_nxt = '0;
          if (in_ch.frame_start) begin
            low_nxt  = ONE_32;
            high_nxt = '0;
          end
          if (is_depth) begin
            if (mode_r == MODE_DLIN) begin
              mul_req.start = 1'b1;
              mul_req.a     = MUL_W'(near_r);
              mul_req.b     = MUL_W'(far_r);
              state_nxt     = ST_MUL_NF;
            end else begin
              depth_nxt = in_ch.chan_zero;
              state_nxt = ST_DEPTH;
            end
          end else if (in_ch.cmd == CMD_CONVERT) begin
            state_nxt = ST_BYTES;
          end
        end
      end
      ST_MUL_NF: begin
        if (mul_rsp.done) begin
          nf_nxt        = mul_rsp.product[61:0];
          mul_req.start = 1'b1;
          mul_req.a     = mag_v;
          mul_req.b     = mag_d;
          state_nxt     = ST_MUL_VD;
        end
      end
      ST_MUL_VD: begin
        if (mul_rsp.done) begin
          d2_nxt    = $signed(64'(far_r) << FRAC_BITS) - sprod;
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: begin
        if ({33'd0, nf_hi} >= den) begin
          depth_nxt = {1'b0, {(CHAN_W-1){1'b1}}};
          state_nxt = ST_DEPTH;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = DIV_W'(nf_hi);
          div_req.low_bits = {nf_r[30:0], 1'b0};
          div_req.steps    = DIV_CNT_W'(LIN_STEPS);
          div_req.divisor  = den;
          state_nxt        = ST_DIV_LIN;
        end
      end
      ST_DIV_LIN: begin
        if (div_rsp.done) begin
          depth_nxt = $signed(div_rsp.quo);
          state_nxt = ST_DEPTH;
        end
      end
      ST_DEPTH: begin
        if (cmd_r == CMD_SCAN) begin
          if (depth_r < low_r) begin
            low_nxt = depth_r;
          end
          if (depth_r > high_r) begin
            high_nxt = depth_r;
          end
          state_nxt = ST_IDLE;
        end else begin
          range_nxt = (rng_raw < 33'sd1) ? 33'sd1 : rng_raw;
          num_nxt   = num_raw;
          state_nxt = ST_DCHK;
        end
      end
      ST_DCHK: begin
        if (num_r <= 33'sd0) begin
          dbyte_nxt = '0;
          state_nxt = ST_BYTES;
        end else if (num_r >= range_r) begin
          dbyte_nxt = 8'd255;
          state_nxt = ST_BYTES;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = DIV_W'(bdvd[41:8]);
          div_req.low_bits = {bdvd[7:0], 24'd0};
          div_req.steps    = DIV_CNT_W'(BYTE_STEPS);
          div_req.divisor  = DIV_W'({range_r[CHAN_W-1:0], 1'b0});
          state_nxt        = ST_DIV_BYTE;
        end
      end
      ST_DIV_BYTE: begin
        if (div_rsp.done) begin
          dbyte_nxt = div_rsp.quo[BYTE_W-1:0];
          state_nxt = ST_BYTES;
        end
      end
      ST_BYTES: begin
        pix_nxt[idx_r] = byte_val;
        idx_nxt        = idx_r + 1'b1;
        if (idx_r == 2'd3) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_pix_nxt   = pix_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_RGB;
      count_r     <= CNT_W'(4);
      near_r      <= NEAR_RST;
      far_r       <= FAR_RST;
      low_r       <= ONE_32;
      high_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      near_r      <= near_nxt;
      far_r       <= far_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    c0_r      <= c0_nxt;
    c1_r      <= c1_nxt;
    c2_r      <= c2_nxt;
    c3_r      <= c3_nxt;
    nf_r      <= nf_nxt;
    d2_r      <= d2_nxt;
    depth_r   <= depth_nxt;
    range_r   <= range_nxt;
    num_r     <= num_nxt;
    dbyte_r   <= dbyte_nxt;
    pix_r     <= pix_nxt;
    out_pix_r <= out_pix_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_byte   = out_pix_r[0];
  assign out_ch.green_byte = out_pix_r[1];
  assign out_ch.blue_byte  = out_pix_r[2];
  assign out_ch.alpha_byte = out_pix_r[3];

endmodule

// ===== sv/bpr8_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module bpr8_mul
  import bpr8_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [MUL_W-1:0]     mplr_r, mplr_nxt;
  logic [PROD_W-1:0]    acc_r, acc_nxt;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    mplr_nxt  = mplr_r;
    acc_nxt   = acc_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = MUL_CNT_W'(MUL_STEPS);
      mcand_nxt = PROD_W'(req.a);
      mplr_nxt  = req.b;
      acc_nxt   = '0;
    end else if (busy_r) begin
      if (mplr_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r << 1;
      mplr_nxt  = mplr_r >> 1;
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    mplr_r  <= mplr_nxt;
    acc_r   <= acc_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

// ===== sv/bpr8_div.sv =====
// Restoring divider, one quotient bit per cycle, remainder seeded by the caller.
module bpr8_div
  import bpr8_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_LOW_W-1:0] low_r, low_nxt;
  logic [DIV_LOW_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 ge;

  always_comb begin
    trial = {rem_r, low_r[DIV_LOW_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem_init;
      low_nxt  = req.low_bits;
      quo_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low_nxt = low_r << 1;
      quo_nxt = {quo_r[DIV_LOW_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
